// ----- rtl/wake_gate_long_press_defines.svh -----
// Assertion macros shared by the wake gate RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef WAKE_GATE_LONG_PRESS_DEFINES_SVH
`define WAKE_GATE_LONG_PRESS_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define WGLP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wake gate check failed");

// The consequent must hold in the cycle after the antecedent.
`define WGLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wake gate check failed");

`else

`define WGLP_ASSERT_SAME(label, ante, cons)
`define WGLP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/wglp_pkg.sv -----
`timescale 1ns / 1ps

package wglp_pkg;

    localparam int unsigned TIME_W = 32;

    // Blink half period of the green LED in milliseconds; must be a power of two.
    localparam int unsigned BLINK_PERIOD_MS = 256;
    localparam int unsigned BLINK_SHIFT     = $clog2(BLINK_PERIOD_MS);

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned CFG_ADDR_W  = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_FOREVER_SLEEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADLINE_MS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS_MS = 2'd2;

    localparam logic [TIME_W-1:0] DEADLINE_MS_RESET   = 32'd30000;
    localparam logic [TIME_W-1:0] LONG_PRESS_MS_RESET = 32'd3000;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_POLL  = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        OUT_NONE        = 3'd0,
        OUT_TIMER       = 3'd1,
        OUT_ACCEPT      = 3'd2,
        OUT_REJ_RELEASE = 3'd3,
        OUT_REJ_IDLE    = 3'd4
    } outcome_t;

    typedef struct packed
    {
        op_t                op;
        logic [TIME_W-1:0]  time_ms;
        logic               sample_first;
        logic               sample_second;
        logic               pressed_at_wake;
    } item_t;

    typedef struct packed
    {
        logic               forever_sleep;
        logic [TIME_W-1:0]  deadline_ms;
        logic [TIME_W-1:0]  long_press_ms;
    } cfg_t;

    typedef struct packed
    {
        logic               running;
        logic [TIME_W-1:0]  run_start;
        logic               holding;
        logic [TIME_W-1:0]  hold_start;
    } state_t;

    typedef struct packed
    {
        logic               led_green;
        logic               finished;
        outcome_t           outcome;
        logic [TIME_W-1:0]  active_ms;
    } result_t;

endpackage

// ----- rtl/wglp_core.sv -----
`timescale 1ns / 1ps

module wglp_core
(
    input  wglp_pkg::item_t   item,
    input  wglp_pkg::cfg_t    cfg,
    input  wglp_pkg::state_t  state,
    output wglp_pkg::state_t  state_next,
    output wglp_pkg::result_t res
);
    import wglp_pkg::*;

    logic              pressed;
    logic [TIME_W-1:0] active;
    logic [TIME_W-1:0] hold_base;
    logic [TIME_W-1:0] held;
    logic              long_held;
    logic              blink_led;

    assign pressed   = item.sample_first & item.sample_second;
    assign active    = item.time_ms - state.run_start;
    // A fresh press starts its hold at this item, so the held time is then zero.
    assign hold_base = state.holding ? state.hold_start : item.time_ms;
    assign held      = item.time_ms - hold_base;
    assign long_held = (held >= cfg.long_press_ms);
    assign blink_led = long_held ? ~item.time_ms[BLINK_SHIFT] : 1'b1;

    always_comb
    begin
        state_next = state;
        res        = '{led_green: 1'b0, finished: 1'b0, outcome: OUT_NONE,
                       active_ms: '0};
        if (item.op == OP_START)
        begin
            state_next.running    = 1'b1;
            state_next.run_start  = item.time_ms;
            state_next.holding    = item.pressed_at_wake & pressed;
            state_next.hold_start = (item.pressed_at_wake & pressed) ? item.time_ms : '0;
            res.led_green         = 1'b1;
        end
        else if (state.running)
        begin
            if (!cfg.forever_sleep && (active >= cfg.deadline_ms))
            begin
                state_next.running = 1'b0;
                state_next.holding = 1'b0;
                res.finished       = 1'b1;
                res.outcome        = OUT_TIMER;
                res.active_ms      = active;
            end
            else if (pressed)
            begin
                state_next.holding    = 1'b1;
                state_next.hold_start = hold_base;
                res.led_green         = blink_led;
            end
            else if (state.holding)
            begin
                state_next.running = 1'b0;
                state_next.holding = 1'b0;
                res.finished       = 1'b1;
                res.outcome        = long_held ? OUT_ACCEPT : OUT_REJ_RELEASE;
                res.active_ms      = active;
            end
            else if (active >= cfg.long_press_ms)
            begin
                state_next.running = 1'b0;
                state_next.holding = 1'b0;
                res.finished       = 1'b1;
                res.outcome        = OUT_REJ_IDLE;
                res.active_ms      = active;
            end
            else
            begin
                res.led_green = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/wake_gate_long_press.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         tuser: op; tdata: time_ms, sample_first, sample_second,
//                      pressed_at_wake
// m_axis    out        tlast: finished; tdata: led_green, outcome, active_ms
// cfg       in         cfg_we, cfg_addr, cfg_wdata (one write per cycle)
//
// One transaction per cycle sustained while m_tready stays high; an input register
// is followed by a result register with the decision logic between them.
// The run state updates when an item moves into the result register, so the
// next item always sees the state left by the previous one.
// A stall on m_axis fills the input register and then drops s_tready.
// Reset clears the run state and both valid flags, and returns the configuration
// to its reset values.

`include "wake_gate_long_press_defines.svh"

module wake_gate_long_press
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // time_ms [31:0], sample_first [32], sample_second [33],
    // pressed_at_wake [34], zero fill [39:35]
    input  logic [wglp_pkg::IN_TDATA_W-1:0]      s_tdata,
    // op [0]
    input  logic [0:0]                           s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // led_green [0], outcome [3:1], active_ms [35:4], zero fill [39:36]
    output logic [wglp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,

    input  logic                                 cfg_we,
    input  logic [wglp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [wglp_pkg::TIME_W-1:0]          cfg_wdata
);
    import wglp_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forever_sleep <= 1'b0;
            cfg_reg.deadline_ms   <= DEADLINE_MS_RESET;
            cfg_reg.long_press_ms <= LONG_PRESS_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FOREVER_SLEEP: cfg_reg.forever_sleep <= cfg_wdata[0];
                CFG_DEADLINE_MS:   cfg_reg.deadline_ms   <= cfg_wdata;
                CFG_LONG_PRESS_MS: cfg_reg.long_press_ms <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.op              <= op_t'(s_tuser[0]);
            item_reg.time_ms         <= s_tdata[TIME_W-1:0];
            item_reg.sample_first    <= s_tdata[TIME_W];
            item_reg.sample_second   <= s_tdata[TIME_W+1];
            item_reg.pressed_at_wake <= s_tdata[TIME_W+2];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    wglp_core u_core
    (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.finished;
    assign m_tdata  = {4'b0, res_reg.active_ms, res_reg.outcome, res_reg.led_green};

    `WGLP_ASSERT_SAME(a_hold_needs_run, state_reg.holding, state_reg.running)
    `WGLP_ASSERT_SAME(a_finish_led_off, m_tvalid && m_tlast, !m_tdata[0])
    `WGLP_ASSERT_SAME(a_open_no_outcome, m_tvalid && !m_tlast, m_tdata[35:1] == 35'd0)
    `WGLP_ASSERT_NEXT(a_finish_closes_run, advance && res_next.finished, !state_reg.running)
    `WGLP_ASSERT_SAME(a_empty_accepts, !in_valid_reg, s_tready)

endmodule

// ----- sim/wglp_checker.sv -----
`timescale 1ns / 1ps

module wglp_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    // time_ms [31:0], sample_first [32], sample_second [33],
    // pressed_at_wake [34], zero fill [39:35]
    input  logic [wglp_pkg::IN_TDATA_W-1:0]      s_tdata,
    // op [0]
    input  logic [0:0]                           s_tuser,

    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // led_green [0], outcome [3:1], active_ms [35:4], zero fill [39:36]
    input  logic [wglp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 m_tlast,

    input  logic                                 cfg_we,
    input  logic [wglp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [wglp_pkg::TIME_W-1:0]          cfg_wdata,

    output int                                   n_pending,
    output int                                   n_errors,
    output int                                   n_ended
);

    import wglp_pkg::*;

    // Register copies and run state of the gate as the checker sees them.
    logic               sleep_forever = 1'b0;
    logic [TIME_W-1:0]  deadline      = DEADLINE_MS_RESET;
    logic [TIME_W-1:0]  long_press    = LONG_PRESS_MS_RESET;
    logic               in_run        = 1'b0;
    logic [TIME_W-1:0]  run_t0        = '0;
    logic               in_hold       = 1'b0;
    logic [TIME_W-1:0]  hold_t0       = '0;

    result_t            due_results[$];
    int                 pending_cnt   = 0;
    int                 error_cnt     = 0;
    int                 ended_cnt     = 0;

    assign n_pending = pending_cnt;
    assign n_errors  = error_cnt;
    assign n_ended   = ended_cnt;

    task automatic report(input string msg);
        $display("[%0t] wake gate mismatch: %s", $time, msg);
        error_cnt++;
    endtask

    // Applies one accepted transaction to the run state and returns the result it should cause.
    function automatic result_t advance_gate(input item_t it);
        result_t            r;
        logic               pressed;
        logic [TIME_W-1:0]  active;
        logic [TIME_W-1:0]  held;
        r         = '0;
        r.outcome = OUT_NONE;
        pressed   = it.sample_first & it.sample_second;
        if (it.op == OP_START)
        begin
            in_run      = 1'b1;
            run_t0      = it.time_ms;
            in_hold     = it.pressed_at_wake & pressed;
            hold_t0     = in_hold ? it.time_ms : '0;
            r.led_green = 1'b1;
        end
        else if (in_run)
        begin
            active = it.time_ms - run_t0;
            if (!sleep_forever && active >= deadline)
            begin
                r.finished  = 1'b1;
                r.outcome   = OUT_TIMER;
                r.active_ms = active;
            end
            else if (pressed)
            begin
                if (!in_hold)
                begin
                    in_hold = 1'b1;
                    hold_t0 = it.time_ms;
                end
                held = it.time_ms - hold_t0;
                // Past the threshold the LED is lit in the even blink half periods.
                r.led_green = (held >= long_press) ? ~it.time_ms[BLINK_SHIFT] : 1'b1;
            end
            else if (in_hold)
            begin
                held        = it.time_ms - hold_t0;
                r.finished  = 1'b1;
                r.outcome   = (held >= long_press) ? OUT_ACCEPT : OUT_REJ_RELEASE;
                r.active_ms = active;
            end
            else if (active >= long_press)
            begin
                r.finished  = 1'b1;
                r.outcome   = OUT_REJ_IDLE;
                r.active_ms = active;
            end
            else
            begin
                r.led_green = 1'b1;
            end
            if (r.finished)
            begin
                in_run  = 1'b0;
                in_hold = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t want;
        if (!rst_n)
        begin
            sleep_forever = 1'b0;
            deadline      = DEADLINE_MS_RESET;
            long_press    = LONG_PRESS_MS_RESET;
            in_run        = 1'b0;
            run_t0        = '0;
            in_hold       = 1'b0;
            hold_t0       = '0;
            due_results.delete();
            pending_cnt <= 0;
        end
        else
        begin
            // Results trail their items, so compare before adding this edge's item.
            if (m_tvalid && m_tready)
            begin
                if (m_tlast)
                    ended_cnt++;
                if (due_results.size() == 0)
                begin
                    report($sformatf("result %h (last %b) with nothing outstanding",
                                     m_tdata, m_tlast));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[0] != want.led_green)
                        report($sformatf("led_green got %b, expected %b",
                                         m_tdata[0], want.led_green));
                    if (m_tlast != want.finished)
                        report($sformatf("finished got %b, expected %b",
                                         m_tlast, want.finished));
                    if (m_tdata[3:1] != want.outcome)
                        report($sformatf("outcome got %0d, expected %0d (%s)",
                                         m_tdata[3:1], want.outcome, want.outcome.name()));
                    if (m_tdata[35:4] != want.active_ms)
                        report($sformatf("active_ms got %0d, expected %0d",
                                         m_tdata[35:4], want.active_ms));
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.op              = op_t'(s_tuser[0]);
                it.time_ms         = s_tdata[31:0];
                it.sample_first    = s_tdata[32];
                it.sample_second   = s_tdata[33];
                it.pressed_at_wake = s_tdata[34];
                due_results.push_back(advance_gate(it));
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_FOREVER_SLEEP: sleep_forever = cfg_wdata[0];
                    CFG_DEADLINE_MS:   deadline      = cfg_wdata;
                    CFG_LONG_PRESS_MS: long_press    = cfg_wdata;
                    default:           ;
                endcase
            end
            pending_cnt <= due_results.size();
        end
    end

endmodule

// ----- sim/tb_wake_gate_long_press.sv -----
`timescale 1ns / 1ps

module tb_wake_gate_long_press;

    import wglp_pkg::*;

    localparam int ITEM_TARGET  = 1250;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 400000;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [IN_TDATA_W-1:0]       s_tdata   = '0;
    logic [0:0]                  s_tuser   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]      m_tdata;
    logic                        m_tlast;
    logic                        cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]       cfg_addr  = '0;
    logic [TIME_W-1:0]           cfg_wdata = '0;

    int n_pending;
    int n_errors;
    int n_ended;

    int cycles      = 0;
    int n_sent      = 0;
    int n_settings  = 0;
    int burst_left  = 0;
    int step_cap    = 400;
    int ready_mode  = 0;
    int ready_span  = 0;

    wake_gate_long_press u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    wglp_checker u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .n_pending (n_pending),
        .n_errors  (n_errors),
        .n_ended   (n_ended)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("cycle limit hit with %0d results outstanding", n_pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver switches between always ready, coin flips, a fixed duty pattern
    // and sparse ready (one chance in four), holding each mode for a random stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_mode <= 0;
            ready_span <= 0;
        end
        else
        begin
            if (ready_span == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                ready_span <= $urandom_range(20, 120);
            end
            else
            begin
                ready_span <= ready_span - 1;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (cycles[2:0] < 3'd5);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(input op_t op, input logic [TIME_W-1:0] t,
                             input logic sf, input logic ss, input logic wake_pressed);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, wake_pressed, ss, sf, t};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        n_sent++;
    endtask

    // Stops sending until every expected result is back, then lets the pipe settle.
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (n_pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_config(input logic fs, input logic [TIME_W-1:0] dl,
                              input logic [TIME_W-1:0] lp);
        drain(4);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_FOREVER_SLEEP;
        cfg_wdata <= {31'b0, fs};
        @(posedge clk);
        cfg_addr  <= CFG_DEADLINE_MS;
        cfg_wdata <= dl;
        @(posedge clk);
        cfg_addr  <= CFG_LONG_PRESS_MS;
        cfg_wdata <= lp;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        n_settings++;
        // Poll spacing follows the press threshold so that holds cross it in a few polls.
        step_cap = (lp / 3 > 400) ? 400 : ((lp / 3 < 4) ? 4 : int'(lp / 3));
    endtask

    // One run: a start, then polls with the button held over a random window of them.
    task automatic press_session();
        logic [TIME_W-1:0] t;
        logic              sf;
        logic              ss;
        int                polls;
        int                hold_a;
        int                hold_b;
        polls  = $urandom_range(1, 14);
        hold_a = $urandom_range(0, polls);
        hold_b = $urandom_range(hold_a, polls + 1);
        t      = $urandom;
        if (hold_a == 0)
            send_item(OP_START, t, 1'b1, 1'b1, $urandom_range(0, 5) != 0);
        else
            send_item(OP_START, t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        for (int i = 1; i <= polls; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                t = $urandom;
            else
                t = t + $urandom_range(0, step_cap);
            if (i >= hold_a && i < hold_b)
            begin
                sf = 1'b1;
                ss = 1'b1;
                // A bounce on either sample reads as a release.
                if ($urandom_range(0, 9) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                        sf = 1'b0;
                    else
                        ss = 1'b0;
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       {sf, ss} = 2'b00;
                    1:       {sf, ss} = 2'b10;
                    default: {sf, ss} = 2'b01;
                endcase
            end
            send_item(OP_POLL, t, sf, ss, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic noise_items();
        repeat ($urandom_range(1, 4))
            send_item(op_t'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int phase_end;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset register values.
        send_item(OP_POLL,  32'd0,          1'b1, 1'b1, 1'b1);
        send_item(OP_START, 32'd100,        1'b1, 1'b1, 1'b1);
        send_item(OP_POLL,  32'd1000,       1'b1, 1'b1, 1'b0);
        send_item(OP_POLL,  32'd3100,       1'b1, 1'b1, 1'b0);
        send_item(OP_POLL,  32'd3400,       1'b1, 1'b1, 1'b0);
        send_item(OP_POLL,  32'd3500,       1'b0, 1'b1, 1'b0);
        // Run that starts just below the counter wrap, with one sample only at wake.
        send_item(OP_START, 32'hFFFF_FF00,  1'b1, 1'b0, 1'b1);
        send_item(OP_POLL,  32'h0000_0100,  1'b1, 1'b1, 1'b0);
        send_item(OP_POLL,  32'h0000_0200,  1'b0, 1'b0, 1'b0);
        send_item(OP_START, 32'd5000,       1'b1, 1'b1, 1'b0);
        send_item(OP_POLL,  32'd6000,       1'b1, 1'b0, 1'b0);
        send_item(OP_START, 32'd7000,       1'b0, 1'b1, 1'b0);
        send_item(OP_POLL,  32'd10000,      1'b0, 1'b0, 1'b1);
        send_item(OP_POLL,  32'd10001,      1'b1, 1'b1, 1'b0);
        send_item(OP_START, 32'd20000,      1'b1, 1'b1, 1'b1);
        send_item(OP_POLL,  32'd50000,      1'b1, 1'b1, 1'b0);
        send_item(OP_START, 32'd0,          1'b0, 1'b0, 1'b0);
        send_item(OP_POLL,  32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0);

        // Zero thresholds with forever-sleep on, then a zero deadline.
        set_config(1'b1, 32'd0, 32'd0);
        send_item(OP_START, 32'd1,          1'b0, 1'b0, 1'b0);
        send_item(OP_POLL,  32'd1,          1'b0, 1'b0, 1'b0);
        send_item(OP_START, 32'd2,          1'b1, 1'b1, 1'b1);
        send_item(OP_POLL,  32'd2,          1'b1, 1'b1, 1'b0);
        send_item(OP_POLL,  32'd2,          1'b0, 1'b0, 1'b0);
        set_config(1'b0, 32'd0, LONG_PRESS_MS_RESET);
        send_item(OP_START, 32'd9,          1'b1, 1'b1, 1'b1);
        send_item(OP_POLL,  32'd9,          1'b1, 1'b1, 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_config(1'b0, $urandom_range(800, 3000), $urandom_range(100, 900));
                1: set_config(1'b1, $urandom, $urandom_range(50, 600));
                2: set_config(1'b0, 32'hFFFF_FFFF, $urandom_range(0, 300));
                3: set_config(1'b0, $urandom_range(0, 400), 32'hFFFF_FFFF);
                4: set_config(1'($urandom_range(0, 1)), $urandom_range(0, 5000),
                              $urandom_range(0, 2000));
                default: set_config(1'b0, $urandom_range(200, 4000), $urandom_range(1, 1500));
            endcase
            phase_end = n_sent + ITEM_TARGET / PHASES;
            while (n_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    noise_items();
                else
                    press_session();
                if ($urandom_range(0, 49) == 0)
                    drain(0);
            end
        end

        drain(10);
        $display("Sent %0d transactions over %0d register settings; %0d runs ended in a decision.",
                 n_sent, n_settings, n_ended);
        $display("Runs covered hold accept and release, idle reject, deadline expiry, ",
                 "forever-sleep, LED blink and counter wrap.");
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wglp_pkg.sv
rtl/wglp_core.sv
rtl/wake_gate_long_press.sv
sim/wglp_checker.sv
sim/tb_wake_gate_long_press.sv
